>>> src/spfau_pkg.sv
// Shared types and constants for the single-precision arithmetic unit.
// No dependencies.
package spfau_pkg;

	localparam int MANT_W = 24;
	localparam int FRAC_W = MANT_W - 1;
	localparam int EXP_W  = 8;
	localparam logic [EXP_W-1:0] EXP_BIAS = 8'd127;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// token handed along the divider chain
	typedef struct packed {
		logic              vld;
		logic              is_div;
		logic              sign;
		logic [EXP_W-1:0]  exp;
		logic [MANT_W:0]   rem;
		logic [MANT_W-1:0] den;
		logic [MANT_W-1:0] quo;
		logic [31:0]       word;
	} spfau_tok_t;

endpackage

>>> src/spfau_div_cell.sv
// One restoring-division cell: one quotient bit per cell, registered output.
// Depends on spfau_pkg.
module spfau_div_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spfau_pkg::spfau_tok_t  tok_in,
	output spfau_pkg::spfau_tok_t  tok_out
);
	import spfau_pkg::*;

	spfau_tok_t      nxt;
	logic            ge;
	logic [MANT_W:0] diff;

	always_comb begin
		nxt  = tok_in;
		diff = tok_in.rem - {1'b0, tok_in.den};
		ge   = (tok_in.rem >= {1'b0, tok_in.den});
		if (tok_in.is_div) begin
			nxt.quo = {tok_in.quo[MANT_W-2:0], ge};
			nxt.rem = ge ? {diff[MANT_W-1:0], 1'b0} : {tok_in.rem[MANT_W-1:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out <= nxt;
		end
	end

endmodule

>>> src/single_precision_float_arith_unit.sv
// Top level of the single-precision add/sub/mul/div unit.
// Depends on spfau_pkg and spfau_div_cell.
//
// One transaction per cycle: busy is never raised, so start may be held high
// continuously. Every transaction yields exactly one result, strobed by done
// for one cycle, along the same path in every mode (three front stages,
// a chain of 24 division cells that retires one quotient bit each, one output
// register). Results leave in acceptance order; the receiver cannot stall.
module single_precision_float_arith_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  mode,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        busy,
	output logic        done,
	output logic [31:0] result_word
);
	import spfau_pkg::*;

	// stage 1: unpack, align, multiply
	logic              sa, sb;
	logic [EXP_W-1:0]  ea, eb, exp_c1;
	logic [MANT_W-1:0] ma, mb, ma_c1, mb_c1;
	logic [2*MANT_W-1:0] prod_c1;
	op_t               op_in;

	logic              vld_s1, sa_s1, sb_s1;
	op_t               op_s1;
	logic [EXP_W-1:0]  exp_s1;
	logic [MANT_W-1:0] ma_s1, mb_s1;
	logic [2*MANT_W-1:0] prod_s1;

	always_comb begin
		op_in = op_t'(mode);
		sa = operand_a[31];
		sb = operand_b[31] ^ (op_in == OP_SUB);
		ea = operand_a[30:FRAC_W];
		eb = operand_b[30:FRAC_W];
		ma = {1'b1, operand_a[FRAC_W-1:0]};
		mb = {1'b1, operand_b[FRAC_W-1:0]};
		prod_c1 = {{MANT_W{1'b0}}, ma} * {{MANT_W{1'b0}}, mb};
		ma_c1 = ma;
		mb_c1 = mb;
		exp_c1 = ea;
		unique case (op_in)
			OP_ADD, OP_SUB: begin
				if (ea > eb) begin
					mb_c1  = mb >> (ea - eb);
					exp_c1 = ea;
				end else begin
					ma_c1  = ma >> (eb - ea);
					exp_c1 = eb;
				end
			end
			OP_MUL: exp_c1 = ea + eb - EXP_BIAS;
			OP_DIV: exp_c1 = ea - eb + EXP_BIAS;
			default: exp_c1 = ea;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= op_in;
		sa_s1   <= sa;
		sb_s1   <= sb;
		exp_s1  <= exp_c1;
		ma_s1   <= ma_c1;
		mb_s1   <= mb_c1;
		prod_s1 <= prod_c1;
	end

	// stage 2: magnitude add/sub, multiply rounding
	logic              sign_c2, zero_c2;
	logic [MANT_W:0]   mag_c2;
	logic [MANT_W-1:0] fr_c2;
	logic [EXP_W-1:0]  emul_c2;
	logic [31:0]       word_c2;

	logic              vld_s2, sign_s2, zero_s2;
	op_t               op_s2;
	logic [EXP_W-1:0]  exp_s2;
	logic [MANT_W:0]   mag_s2;
	logic [MANT_W-1:0] ma_s2, mb_s2;
	logic [31:0]       word_s2;

	always_comb begin
		zero_c2 = 1'b0;
		sign_c2 = sa_s1;
		mag_c2  = '0;
		if (sa_s1 == sb_s1) begin
			mag_c2 = {1'b0, ma_s1} + {1'b0, mb_s1};
		end else if (ma_s1 == mb_s1) begin
			zero_c2 = 1'b1;
		end else if (ma_s1 > mb_s1) begin
			mag_c2 = {1'b0, ma_s1} - {1'b0, mb_s1};
		end else begin
			mag_c2  = {1'b0, mb_s1} - {1'b0, ma_s1};
			sign_c2 = sb_s1;
		end
		if (op_s1 == OP_MUL || op_s1 == OP_DIV) begin
			sign_c2 = sa_s1 ^ sb_s1;
		end
		if (prod_s1[2*MANT_W-1]) begin
			emul_c2 = exp_s1 + 8'd1;
			fr_c2 = {1'b0, prod_s1[2*MANT_W-2:MANT_W]} + {{FRAC_W{1'b0}}, prod_s1[MANT_W-1]};
		end else begin
			emul_c2 = exp_s1;
			fr_c2 = {1'b0, prod_s1[2*MANT_W-3:MANT_W-1]} + {{FRAC_W{1'b0}}, prod_s1[MANT_W-2]};
		end
		if (fr_c2[FRAC_W]) begin
			fr_c2   = '0;
			emul_c2 = emul_c2 + 8'd1;
		end
		word_c2 = {sign_c2, emul_c2, fr_c2[FRAC_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2   <= op_s1;
		sign_s2 <= sign_c2;
		zero_s2 <= zero_c2;
		exp_s2  <= exp_s1;
		mag_s2  <= mag_c2;
		ma_s2   <= ma_s1;
		mb_s2   <= mb_s1;
		word_s2 <= word_c2;
	end

	// stage 3: normalize add/sub, launch token into the chain
	logic [MANT_W:0]  mag_n;
	logic [EXP_W-1:0] exp_n;
	logic [4:0]       top_idx;
	logic [4:0]       sh;
	spfau_tok_t       tok_c3;
	spfau_tok_t       tok [MANT_W+1];

	always_comb begin
		top_idx = '0;
		for (int i = 0; i < FRAC_W; i++) begin
			if (mag_s2[i]) top_idx = 5'(i);
		end
		sh    = 5'(FRAC_W) - top_idx;
		mag_n = mag_s2;
		exp_n = exp_s2;
		if (mag_s2[MANT_W]) begin
			mag_n = mag_s2 >> 1;
			exp_n = exp_s2 + 8'd1;
		end else if (!mag_s2[FRAC_W]) begin
			mag_n = mag_s2 << sh;
			exp_n = exp_s2 - {3'b0, sh};
		end
		tok_c3.vld    = vld_s2;
		tok_c3.is_div = (op_s2 == OP_DIV);
		tok_c3.sign   = sign_s2;
		tok_c3.exp    = exp_s2;
		tok_c3.rem    = {1'b0, ma_s2};
		tok_c3.den    = mb_s2;
		tok_c3.quo    = '0;
		if (op_s2 == OP_MUL) begin
			tok_c3.word = word_s2;
		end else if (zero_s2) begin
			tok_c3.word = {1'b1, 31'b0};
		end else begin
			tok_c3.word = {sign_s2, exp_n, mag_n[FRAC_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok[0] <= '0;
		end else begin
			tok[0] <= tok_c3;
		end
	end

	for (genvar k = 0; k < MANT_W; k++) begin : g_cell
		spfau_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok[k]),
			.tok_out(tok[k+1])
		);
	end

	// output: renormalize quotient, pass other results through
	spfau_tok_t       last;
	logic [31:0]      word_o;
	logic             done_q;
	logic [31:0]      result_q;

	always_comb begin
		last = tok[MANT_W];
		if (!last.is_div) begin
			word_o = last.word;
		end else if (last.quo[FRAC_W]) begin
			word_o = {last.sign, last.exp, last.quo[FRAC_W-1:0]};
		end else begin
			word_o = {last.sign, last.exp - 8'd1, last.quo[FRAC_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= word_o;
	end

	assign busy        = 1'b0;
	assign done        = done_q;
	assign result_word = result_q;

endmodule

>>> src/spfau_checker.sv
// Port-level checks for the single-precision arithmetic unit, and its bind.
// Depends on single_precision_float_arith_unit.
module spfau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] result_word
);
	localparam int LAT = 28;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done) else $error("result missing");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT)) else $error("result without transaction");

endmodule

bind single_precision_float_arith_unit spfau_checker u_spfau_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.result_word(result_word)
);
